// ===== rtl/amis_pkg.sv =====
// Shared types and constants for the agent motion integration step.
// Payload word types, field widths, register indexes and register reset values.
// No dependencies.
`default_nettype none

package amis_pkg;

    localparam int POS_W     = 18;
    localparam int VEL_W     = 16;
    localparam int VEL_FRAC  = 8;
    localparam int CAP_W     = 15;
    localparam int DT_W      = 16;
    localparam int CFG_W     = 10;
    localparam int CELL_W    = 10;
    localparam int CFG_IDX_W = 2;

    // dt * v is Q8.24
    localparam int PROD_W    = DT_W + VEL_W + 1;
    localparam int PROD_FRAC = 24;

    // speed limit arithmetic
    localparam int MAG2_W    = 2 * VEL_W;
    localparam int ROOT_W    = 24;
    localparam int SCALE_Q_W = CAP_W;

    localparam logic [CFG_W-1:0] WORLD_WIDTH_RST  = 10'd960;
    localparam logic [CFG_W-1:0] WORLD_HEIGHT_RST = 10'd480;
    localparam logic [CFG_W-1:0] CELL_SIZE_RST    = 10'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WORLD_WIDTH  = 2'd0,
        REG_WORLD_HEIGHT = 2'd1,
        REG_CELL_SIZE    = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic        [POS_W-1:0] pos_x;
        logic        [POS_W-1:0] pos_y;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic signed [VEL_W-1:0] acc_x;
        logic signed [VEL_W-1:0] acc_y;
        logic        [CAP_W-1:0] speed_cap;
        logic        [DT_W-1:0]  time_step;
    } in_word_t;

    typedef struct packed {
        logic        [POS_W-1:0]  new_pos_x;
        logic        [POS_W-1:0]  new_pos_y;
        logic signed [VEL_W-1:0]  new_vel_x;
        logic signed [VEL_W-1:0]  new_vel_y;
        logic        [CELL_W-1:0] cell_x;
        logic        [CELL_W-1:0] cell_y;
    } out_word_t;

endpackage

`default_nettype wire

// ===== rtl/amis_delay.sv =====
// Enabled delay line that keeps side data aligned with the arithmetic stages.
// No package dependencies.
`default_nettype none

module amis_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] pipe_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign dout = pipe_reg[DEPTH-1];

endmodule

`default_nettype wire

// ===== rtl/amis_div.sv =====
// Pipelined restoring divider, SPS quotient bits per register stage.
// Caller supplies the starting remainder (must be below den) and the low numerator bits.
// No package dependencies.
`default_nettype none

module amis_div #(
    parameter int DEN_W = 24,
    parameter int Q_W   = 15,
    parameter int SPS   = 4
) (
    input  logic             clk,
    input  logic             en,
    input  logic [DEN_W-1:0] rem_init,
    input  logic [Q_W-1:0]   lo_init,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quot
);

    localparam int NST = (Q_W + SPS - 1) / SPS;

    logic [DEN_W-1:0] rem_reg [NST];
    logic [Q_W-1:0]   lo_reg  [NST];
    logic [DEN_W-1:0] den_reg [NST];

    for (genvar s = 0; s < NST; s++)
    begin : g_st
        logic [DEN_W-1:0] rem_in;
        logic [Q_W-1:0]   lo_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W-1:0] rem_next;
        logic [Q_W-1:0]   lo_next;

        if (s == 0)
        begin : g_first
            assign rem_in = rem_init;
            assign lo_in  = lo_init;
            assign den_in = den;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign lo_in  = lo_reg[s-1];
            assign den_in = den_reg[s-1];
        end

        // numerator bits shift out of lo at the top, quotient bits shift in at the bottom
        always_comb
        begin
            logic [DEN_W:0] t;
            rem_next = rem_in;
            lo_next  = lo_in;
            t        = '0;
            for (int k = 0; k < SPS; k++)
            begin
                if (s * SPS + k < Q_W)
                begin
                    t = {rem_next, lo_next[Q_W-1]};
                    if (t >= {1'b0, den_in})
                    begin
                        rem_next = DEN_W'(t - {1'b0, den_in});
                        lo_next  = {lo_next[Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = t[DEN_W-1:0];
                        lo_next  = {lo_next[Q_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rem_next;
                lo_reg[s]  <= lo_next;
                den_reg[s] <= den_in;
            end
        end
    end

    assign quot = lo_reg[NST-1];

endmodule

`default_nettype wire

// ===== rtl/amis_sqrt.sv =====
// Pipelined digit-by-digit integer square root, SPS root bits per register stage.
// Returns floor(sqrt(rad)). No package dependencies.
`default_nettype none

module amis_sqrt #(
    parameter int RAD_W = 48,
    parameter int SPS   = 4
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [RAD_W-1:0]     rad,
    output logic [RAD_W/2-1:0]   root
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 1;
    localparam int NST    = (ROOT_W + SPS - 1) / SPS;

    logic [REM_W-1:0]  rem_reg  [NST];
    logic [ROOT_W-1:0] root_reg [NST];
    logic [RAD_W-1:0]  rad_reg  [NST];

    for (genvar s = 0; s < NST; s++)
    begin : g_st
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;
        logic [RAD_W-1:0]  rad_next;

        if (s == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign rad_in  = rad_reg[s-1];
        end

        // bring down two radicand bits, try subtracting 4*root+1
        always_comb
        begin
            logic [REM_W+1:0] t;
            logic [REM_W+1:0] trial;
            rem_next  = rem_in;
            root_next = root_in;
            rad_next  = rad_in;
            t         = '0;
            trial     = '0;
            for (int k = 0; k < SPS; k++)
            begin
                if (s * SPS + k < ROOT_W)
                begin
                    t     = {rem_next, rad_next[RAD_W-1 -: 2]};
                    trial = {1'b0, root_next, 2'b01};
                    if (t >= trial)
                    begin
                        rem_next  = REM_W'(t - trial);
                        root_next = {root_next[ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next  = t[REM_W-1:0];
                        root_next = {root_next[ROOT_W-2:0], 1'b0};
                    end
                    rad_next = {rad_next[RAD_W-3:0], 2'b00};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
                rad_reg[s]  <= rad_next;
            end
        end
    end

    assign root = root_reg[NST-1];

endmodule

`default_nettype wire

// ===== rtl/agent_motion_integration_step.sv =====
// Top level: forward Euler motion step of one agent, fully pipelined.
// Uses amis_pkg, amis_delay, amis_div and amis_sqrt.
//
// Usage:
//   Input words (in_valid/in_ready, in_data) carry one agent each; one result word
//   per input leaves on out_valid/out_ready, out_data, in input order.
//   Configuration (world width, world height, cell size) is written through
//   cfg_we/cfg_idx/cfg_wdata while no word is in flight; unknown indexes are ignored.
//   Throughput: one word per cycle while the pipe is not stalled. 15 register
//   stages, the first loads on the accepting edge (4 arithmetic stages,
//   6 square-root stages, 4 divide stages, output register).
//   The square root of the squared speed and the rescale divide set the depth.
//   Stall: when the output word is not taken the whole pipe holds; a one-word
//   input skid buffer catches a word offered in that cycle, and in_ready stays
//   low until the skid drains. in_ready does not depend on out_ready.
//   Reset: rst_n clears all valid bits and the skid, and loads the registers with
//   960, 480 and 100. No clearing pass; the block is ready right after reset.
`default_nettype none

module agent_motion_integration_step #(
    parameter int POS_FRAC_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [amis_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [amis_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  amis_pkg::in_word_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output amis_pkg::out_word_t            out_data
);

    import amis_pkg::*;

    localparam int F      = POS_FRAC_BITS;
    localparam int PSH    = PROD_FRAC - F;
    localparam int PD_W   = PROD_W - PSH;
    localparam int NX_W   = CFG_W + F;
    localparam int PS_W   = (POS_W > NX_W ? POS_W : NX_W) + 2;
    localparam int DV_W   = PROD_W - 2 * VEL_FRAC;
    localparam int NUM_W  = CAP_W + VEL_W;
    localparam int NUM8_W = NUM_W + VEL_FRAC;
    localparam int SPS    = 4;
    localparam int SQ_LAT = (ROOT_W + SPS - 1) / SPS;
    localparam int DV_LAT = (SCALE_Q_W + SPS - 1) / SPS;
    localparam int CD_LAT = (CELL_W + SPS - 1) / SPS;
    localparam int S_ROOT = 4 + SQ_LAT;
    localparam int S_Q    = S_ROOT + DV_LAT;
    localparam int LAT    = S_Q + 1;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] world_w_reg;
    logic [CFG_W-1:0] world_h_reg;
    logic [CFG_W-1:0] cell_size_reg;
    logic [CFG_W-1:0] csz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            world_w_reg   <= WORLD_WIDTH_RST;
            world_h_reg   <= WORLD_HEIGHT_RST;
            cell_size_reg <= CELL_SIZE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_WORLD_WIDTH:  world_w_reg   <= cfg_wdata;
                REG_WORLD_HEIGHT: world_h_reg   <= cfg_wdata;
                REG_CELL_SIZE:    cell_size_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // zero cell size acts as one
    assign csz = (cell_size_reg == '0) ? CFG_W'(1) : cell_size_reg;

    // ---------------- flow control ----------------
    logic           en;
    logic           src_v;
    in_word_t       src;
    logic           skid_full_reg;
    logic           skid_full_next;
    in_word_t       skid_data_reg;
    logic [LAT-1:0] vld_reg;

    assign out_valid = vld_reg[LAT-1];
    assign en        = !out_valid || out_ready;
    assign in_ready  = !skid_full_reg;
    assign src_v     = skid_full_reg || in_valid;
    assign src       = skid_full_reg ? skid_data_reg : in_data;

    always_comb
    begin
        skid_full_next = skid_full_reg;
        if (skid_full_reg && en)
        begin
            skid_full_next = 1'b0;
        end
        else if (!skid_full_reg && !en && in_valid)
        begin
            skid_full_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
            vld_reg       <= '0;
        end
        else
        begin
            skid_full_reg <= skid_full_next;
            if (en)
            begin
                vld_reg <= {vld_reg[LAT-2:0], src_v};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_full_reg && !en)
        begin
            skid_data_reg <= in_data;
        end
    end

    // ---------------- stage 1: products of dt ----------------
    logic signed [PROD_W-1:0] mul_px;
    logic signed [PROD_W-1:0] mul_py;
    logic signed [PROD_W-1:0] mul_vx;
    logic signed [PROD_W-1:0] mul_vy;

    assign mul_px = $signed({1'b0, src.time_step}) * $signed(src.vel_x);
    assign mul_py = $signed({1'b0, src.time_step}) * $signed(src.vel_y);
    assign mul_vx = $signed({1'b0, src.time_step}) * $signed(src.acc_x);
    assign mul_vy = $signed({1'b0, src.time_step}) * $signed(src.acc_y);

    logic [PROD_W-1:0]       s1_dpx_reg;
    logic [PROD_W-1:0]       s1_dpy_reg;
    logic [PROD_W-1:0]       s1_dvx_reg;
    logic [PROD_W-1:0]       s1_dvy_reg;
    logic [POS_W-1:0]        s1_px_reg;
    logic [POS_W-1:0]        s1_py_reg;
    logic [VEL_W-1:0]        s1_vx_reg;
    logic [VEL_W-1:0]        s1_vy_reg;
    logic [CAP_W-1:0]        s1_cap_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_dpx_reg <= mul_px;
            s1_dpy_reg <= mul_py;
            s1_dvx_reg <= mul_vx;
            s1_dvy_reg <= mul_vy;
            s1_px_reg  <= src.pos_x;
            s1_py_reg  <= src.pos_y;
            s1_vx_reg  <= src.vel_x;
            s1_vy_reg  <= src.vel_y;
            s1_cap_reg <= src.speed_cap;
        end
    end

    // ---------------- stage 2: integrate ----------------
    function automatic logic [PS_W-1:0] pos_add(input logic [POS_W-1:0] p,
                                                input logic [PROD_W-1:0] prod);
        logic [PD_W-1:0] d;
        d = prod[PROD_W-1:PSH];   // arithmetic shift keeps floor rounding
        return {{(PS_W-POS_W){1'b0}}, p} + {{(PS_W-PD_W){d[PD_W-1]}}, d};
    endfunction

    function automatic logic [VEL_W-1:0] vel_add(input logic [VEL_W-1:0] v,
                                                 input logic [PROD_W-1:0] prod);
        logic [DV_W-1:0]  d;
        logic [VEL_W+1:0] s;
        d = prod[PROD_W-1:2*VEL_FRAC];
        s = {{2{v[VEL_W-1]}}, v} + {d[DV_W-1], d};
        if (!s[VEL_W+1] && (s[VEL_W:VEL_W-1] != 2'b00))
        begin
            return {1'b0, {(VEL_W-1){1'b1}}};
        end
        else if (s[VEL_W+1] && (s[VEL_W:VEL_W-1] != 2'b11))
        begin
            return {1'b1, {(VEL_W-1){1'b0}}};
        end
        return s[VEL_W-1:0];
    endfunction

    logic [PS_W-1:0]  s2_px_reg;
    logic [PS_W-1:0]  s2_py_reg;
    logic signed [VEL_W-1:0] s2_vx_reg;
    logic signed [VEL_W-1:0] s2_vy_reg;
    logic [CAP_W-1:0] s2_cap_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_px_reg  <= pos_add(s1_px_reg, s1_dpx_reg);
            s2_py_reg  <= pos_add(s1_py_reg, s1_dpy_reg);
            s2_vx_reg  <= vel_add(s1_vx_reg, s1_dvx_reg);
            s2_vy_reg  <= vel_add(s1_vy_reg, s1_dvy_reg);
            s2_cap_reg <= s1_cap_reg;
        end
    end

    // ---------------- stage 3: wrap, squares ----------------
    function automatic logic [NX_W-1:0] wrap_coord(input logic [PS_W-1:0] p,
                                                   input logic [CFG_W-1:0] size);
        logic [NX_W-1:0] bound;
        bound = {size, {F{1'b0}}};
        if (p[PS_W-1])
        begin
            return bound;
        end
        else if (p[PS_W-2:0] > (PS_W-1)'(bound))
        begin
            return '0;
        end
        return p[NX_W-1:0];
    endfunction

    logic signed [MAG2_W-1:0] sq_x;
    logic signed [MAG2_W-1:0] sq_y;
    logic [2*CAP_W-1:0]       cap2;

    assign sq_x = s2_vx_reg * s2_vx_reg;
    assign sq_y = s2_vy_reg * s2_vy_reg;
    assign cap2 = s2_cap_reg * s2_cap_reg;

    logic [NX_W-1:0]     s3_nx_reg;
    logic [NX_W-1:0]     s3_ny_reg;
    logic [MAG2_W-2:0]   s3_sqx_reg;
    logic [MAG2_W-2:0]   s3_sqy_reg;
    logic [2*CAP_W-1:0]  s3_cap2_reg;
    logic [VEL_W-1:0]    s3_vx_reg;
    logic [VEL_W-1:0]    s3_vy_reg;
    logic [CAP_W-1:0]    s3_cap_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_nx_reg   <= wrap_coord(s2_px_reg, world_w_reg);
            s3_ny_reg   <= wrap_coord(s2_py_reg, world_h_reg);
            s3_sqx_reg  <= sq_x[MAG2_W-2:0];
            s3_sqy_reg  <= sq_y[MAG2_W-2:0];
            s3_cap2_reg <= cap2;
            s3_vx_reg   <= s2_vx_reg;
            s3_vy_reg   <= s2_vy_reg;
            s3_cap_reg  <= s2_cap_reg;
        end
    end

    // grid cell: floor(floor(pos) / cell_size)
    logic [CELL_W-1:0] cq_x;
    logic [CELL_W-1:0] cq_y;

    amis_div #(.DEN_W(CFG_W), .Q_W(CELL_W), .SPS(SPS)) u_cell_div_x (
        .clk      (clk),
        .en       (en),
        .rem_init ('0),
        .lo_init  (s3_nx_reg[NX_W-1:F]),
        .den      (csz),
        .quot     (cq_x)
    );

    amis_div #(.DEN_W(CFG_W), .Q_W(CELL_W), .SPS(SPS)) u_cell_div_y (
        .clk      (clk),
        .en       (en),
        .rem_init ('0),
        .lo_init  (s3_ny_reg[NX_W-1:F]),
        .den      (csz),
        .quot     (cq_y)
    );

    // ---------------- stage 4: magnitude test, rescale numerators ----------------
    logic [VEL_W-1:0] abs_x;
    logic [VEL_W-1:0] abs_y;
    logic [NUM_W-1:0] num_x;
    logic [NUM_W-1:0] num_y;

    assign abs_x = s3_vx_reg[VEL_W-1] ? VEL_W'(0 - s3_vx_reg) : s3_vx_reg;
    assign abs_y = s3_vy_reg[VEL_W-1] ? VEL_W'(0 - s3_vy_reg) : s3_vy_reg;
    assign num_x = s3_cap_reg * abs_x;
    assign num_y = s3_cap_reg * abs_y;

    logic [MAG2_W-1:0] s4_mag2_reg;
    logic              s4_need_reg;
    logic [NUM_W-1:0]  s4_numx_reg;
    logic [NUM_W-1:0]  s4_numy_reg;
    logic [VEL_W-1:0]  s4_vx_reg;
    logic [VEL_W-1:0]  s4_vy_reg;
    logic [MAG2_W-1:0] mag2;

    assign mag2 = {1'b0, s3_sqx_reg} + {1'b0, s3_sqy_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_mag2_reg <= mag2;
            s4_need_reg <= mag2 > {{(MAG2_W-2*CAP_W){1'b0}}, s3_cap2_reg};
            s4_numx_reg <= num_x;
            s4_numy_reg <= num_y;
            s4_vx_reg   <= s3_vx_reg;
            s4_vy_reg   <= s3_vy_reg;
        end
    end

    // magnitude in Q8.16
    logic [ROOT_W-1:0] mag;

    amis_sqrt #(.RAD_W(2*ROOT_W), .SPS(SPS)) u_sqrt (
        .clk  (clk),
        .en   (en),
        .rad  ({s4_mag2_reg, {(2*ROOT_W-MAG2_W){1'b0}}}),
        .root (mag)
    );

    logic [NUM_W-1:0] numx_d;
    logic [NUM_W-1:0] numy_d;

    amis_delay #(.W(2*NUM_W), .DEPTH(SQ_LAT)) u_num_dly (
        .clk  (clk),
        .en   (en),
        .din  ({s4_numx_reg, s4_numy_reg}),
        .dout ({numx_d, numy_d})
    );

    // cap * |v| * 256 / mag
    logic [NUM8_W-1:0]    num8_x;
    logic [NUM8_W-1:0]    num8_y;
    logic [SCALE_Q_W-1:0] q_x;
    logic [SCALE_Q_W-1:0] q_y;

    assign num8_x = {numx_d, {VEL_FRAC{1'b0}}};
    assign num8_y = {numy_d, {VEL_FRAC{1'b0}}};

    amis_div #(.DEN_W(ROOT_W), .Q_W(SCALE_Q_W), .SPS(SPS)) u_scale_div_x (
        .clk      (clk),
        .en       (en),
        .rem_init (num8_x[NUM8_W-1:SCALE_Q_W]),
        .lo_init  (num8_x[SCALE_Q_W-1:0]),
        .den      (mag),
        .quot     (q_x)
    );

    amis_div #(.DEN_W(ROOT_W), .Q_W(SCALE_Q_W), .SPS(SPS)) u_scale_div_y (
        .clk      (clk),
        .en       (en),
        .rem_init (num8_y[NUM8_W-1:SCALE_Q_W]),
        .lo_init  (num8_y[SCALE_Q_W-1:0]),
        .den      (mag),
        .quot     (q_y)
    );

    // side data up to the quotient stage
    logic             need_d;
    logic [VEL_W-1:0] vx_d;
    logic [VEL_W-1:0] vy_d;
    logic [POS_W-1:0] nx_d;
    logic [POS_W-1:0] ny_d;
    logic [CELL_W-1:0] cx_d;
    logic [CELL_W-1:0] cy_d;

    amis_delay #(.W(1+2*VEL_W), .DEPTH(S_Q-4)) u_vel_dly (
        .clk  (clk),
        .en   (en),
        .din  ({s4_need_reg, s4_vx_reg, s4_vy_reg}),
        .dout ({need_d, vx_d, vy_d})
    );

    amis_delay #(.W(2*POS_W), .DEPTH(S_Q-3)) u_pos_dly (
        .clk  (clk),
        .en   (en),
        .din  ({POS_W'(s3_nx_reg), POS_W'(s3_ny_reg)}),
        .dout ({nx_d, ny_d})
    );

    amis_delay #(.W(2*CELL_W), .DEPTH(S_Q-3-CD_LAT)) u_cell_dly (
        .clk  (clk),
        .en   (en),
        .din  ({cq_x, cq_y}),
        .dout ({cx_d, cy_d})
    );

    // ---------------- output register ----------------
    function automatic logic [VEL_W-1:0] pick_vel(input logic need,
                                                  input logic [VEL_W-1:0] v,
                                                  input logic [SCALE_Q_W-1:0] q);
        logic [VEL_W-1:0] qv;
        qv = {{(VEL_W-SCALE_Q_W){1'b0}}, q};
        if (!need)
        begin
            return v;
        end
        return v[VEL_W-1] ? VEL_W'(0 - qv) : qv;
    endfunction

    out_word_t out_data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg.new_pos_x <= nx_d;
            out_data_reg.new_pos_y <= ny_d;
            out_data_reg.new_vel_x <= pick_vel(need_d, vx_d, q_x);
            out_data_reg.new_vel_y <= pick_vel(need_d, vy_d, q_y);
            out_data_reg.cell_x    <= cx_d;
            out_data_reg.cell_y    <= cy_d;
        end
    end

    assign out_data = out_data_reg;

`ifndef SYNTH
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !en |=> skid_full_reg)
        else $error("word taken during stall did not land in skid");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg && en |=> !skid_full_reg)
        else $error("skid not drained when pipe advanced");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("valid bits moved while pipe stalled");

    a_skid_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> out_valid)
        else $error("skid occupied without a pending output word");
`endif

endmodule

`default_nettype wire

// ===== bench/amis_checker.sv =====
// Checker for agent_motion_integration_step: watches the input, output and register ports,
// predicts each result word and compares it with what the block returns.
// Depends on amis_pkg.
module amis_checker #(
    parameter int POS_FRAC_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [amis_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [amis_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  amis_pkg::in_word_t             in_data,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  amis_pkg::out_word_t            out_data,
    output int                             errors,
    output int                             pending,
    output int                             checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import amis_pkg::*;

    logic [CFG_W-1:0] width_q, height_q, cell_q;
    out_word_t motion_q[$];

    function automatic longint floor_div_pow2(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned root, bit_v;
        root = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n) bit_v >>= 2;
        while (bit_v != 0)
        begin
            if (n >= root + bit_v)
            begin
                n -= root + bit_v;
                root = (root >> 1) + bit_v;
            end
            else
                root >>= 1;
            bit_v >>= 2;
        end
        return root;
    endfunction

    function automatic longint rescale(longint v, longint cap, longint mag);
        longint a, q;
        a = v < 0 ? -v : v;
        q = (cap * a * 256) / mag;
        return v < 0 ? -q : q;
    endfunction

    function automatic longint wrap_coord(longint p, longint size);
        longint bound;
        bound = size << POS_FRAC_BITS;
        if (p < 0) return bound;
        if (p > bound) return 0;
        return p;
    endfunction

    function automatic out_word_t step_agent(in_word_t w);
        out_word_t r;
        longint px, py, vx, vy, dt, cap, mag2, mag, nx, ny, csz;
        dt = w.time_step;
        cap = w.speed_cap;
        vx = w.vel_x;
        vy = w.vel_y;
        px = longint'(w.pos_x) + floor_div_pow2(dt * vx, 24 - POS_FRAC_BITS);
        py = longint'(w.pos_y) + floor_div_pow2(dt * vy, 24 - POS_FRAC_BITS);
        vx = clamp16(vx + floor_div_pow2(dt * longint'(w.acc_x), 16));
        vy = clamp16(vy + floor_div_pow2(dt * longint'(w.acc_y), 16));
        mag2 = vx * vx + vy * vy;
        if (mag2 > cap * cap)
        begin
            mag = int_sqrt(mag2 << 16);
            vx = rescale(vx, cap, mag);
            vy = rescale(vy, cap, mag);
        end
        nx = wrap_coord(px, width_q);
        ny = wrap_coord(py, height_q);
        csz = (cell_q == 0) ? 1 : cell_q;
        r.new_pos_x = nx[POS_W-1:0];
        r.new_pos_y = ny[POS_W-1:0];
        r.new_vel_x = vx[VEL_W-1:0];
        r.new_vel_y = vy[VEL_W-1:0];
        r.cell_x = CELL_W'(nx / (csz << POS_FRAC_BITS));
        r.cell_y = CELL_W'(ny / (csz << POS_FRAC_BITS));
        return r;
    endfunction

    assign pending = motion_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t exp_w;
        if (!rst_n)
        begin
            width_q <= WORLD_WIDTH_RST;
            height_q <= WORLD_HEIGHT_RST;
            cell_q <= CELL_SIZE_RST;
            motion_q.delete();
            errors <= 0;
            checked <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (motion_q.size() == 0)
                begin
                    $display("%0t: unexpected word %p", $time, out_data);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_w = motion_q.pop_front();
                    checked <= checked + 1;
                    if (exp_w !== out_data)
                    begin
                        $display("%0t: expected %p actual %p", $time, exp_w, out_data);
                        errors <= errors + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                motion_q = {motion_q, step_agent(in_data)};
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_WORLD_WIDTH:  width_q <= cfg_wdata;
                    REG_WORLD_HEIGHT: height_q <= cfg_wdata;
                    REG_CELL_SIZE:    cell_q <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== bench/testbench.sv =====
// Top of the agent_motion_integration_step bench: clock, reset, register writes and
// agent word stimulus with random gaps and stalls; verdict from amis_checker.
// Depends on amis_pkg, amis_checker and the block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import amis_pkg::*;

    logic clk, rst_n, cfg_we, in_valid, in_ready, out_valid, out_ready;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0] cfg_wdata;
    in_word_t in_data;
    out_word_t out_data;
    int errors, pending, checked, hold_cycles;
    bit stop_draining;

    agent_motion_integration_step dut (.*);
    amis_checker chk (.*);

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("agent_motion_integration_step: mismatch");
        $finish;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // receiver: random stalls, plus one long hold requested by the sender side
    initial
    begin
        int g;
        out_ready = 0;
        hold_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 0;
                hold_cycles--;
            end
            else if (stop_draining)
                out_ready <= 1;
            else
            begin
                g = gap_len();
                out_ready <= (g == 0);
            end
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    task automatic settle();
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic send_word(in_word_t w, bit no_gap);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0)
        begin
            in_valid <= 0;
            repeat (g) @(negedge clk);
        end
        in_valid <= 1;
        in_data <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic in_word_t rand_word();
        logic [159:0] raw;
        in_word_t w;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        w = raw[$bits(in_word_t)-1:0];
        case ($urandom_range(0, 3))
            0: w.time_step = DT_W'($urandom_range(0, 2000));
            1: begin
                w.vel_x = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
                w.vel_y = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
            end
            2: w.pos_x = POS_W'($urandom_range(0, 300000) % 262144);
            default: ;
        endcase
        if ($urandom_range(0, 9) == 0) w.speed_cap = '0;
        return w;
    endfunction

    initial
    begin
        in_word_t w;
        int settings[5][3];
        settings = '{'{960, 480, 100}, '{1023, 1023, 1023}, '{1, 1, 1},
                     '{0, 0, 0}, '{640, 200, 37}};
        rst_n = 0;
        cfg_we = 0;
        cfg_idx = REG_WORLD_WIDTH;
        cfg_wdata = '0;
        in_valid = 0;
        in_data = '0;
        stop_draining = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: field extremes, wrap both ways, zero cap, saturation
        for (int i = 0; i < 20; i++)
        begin
            w = '0;
            case (i % 10)
                0: w = '1;
                1: begin w.pos_x = '0; w.vel_x = -16'sd32768; w.time_step = '1; end
                2: begin w.pos_y = POS_W'(480 << 8); w.vel_y = 16'sd32767; w.time_step = '1; end
                3: begin w.vel_x = 16'sd32767; w.acc_x = 16'sd32767; w.time_step = '1;
                         w.speed_cap = '1; end
                4: begin w.vel_y = -16'sd32768; w.acc_y = -16'sd32768; w.time_step = '1; end
                5: begin w.vel_x = 16'sd300; w.vel_y = -16'sd400; w.speed_cap = '0;
                         w.time_step = 16'd100; end
                6: begin w.pos_x = '1; w.pos_y = '1; end
                7: begin w.vel_x = 16'sd3; w.vel_y = 16'sd4; w.speed_cap = 15'd5; end
                8: begin w.pos_x = POS_W'(960 << 8); w.pos_y = POS_W'(100 << 8);
                         w.speed_cap = '1; end
                default: w = rand_word();
            endcase
            send_word(w, 0);
        end
        in_valid <= 0;
        settle();

        for (int s = 0; s < 5; s++)
        begin
            write_reg(REG_WORLD_WIDTH, CFG_W'(settings[s][0]));
            write_reg(REG_WORLD_HEIGHT, CFG_W'(settings[s][1]));
            write_reg(REG_CELL_SIZE, CFG_W'(settings[s][2]));
            for (int i = 0; i < 100; i++)
            begin
                if (s == 1 && i == 10)
                    hold_cycles = 60;
                send_word(rand_word(), s == 1 && i < 40);
            end
            in_valid <= 0;
            settle();
        end

        stop_draining = 1;
        settle();
        $display("ran %0d agent words over 5 world/cell settings plus directed edge cases",
                 checked);
        if (errors == 0)
            $display("agent_motion_integration_step: match");
        else
            $display("agent_motion_integration_step: mismatch");
        $finish;
    end
endmodule
